// ===== design/assert_macros.svh =====
// assertion macros shared by the curve evaluator modules
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/bcpe_pkg.sv =====
// shared types and constants for the bezier curve phase evaluator
// no dependencies
`default_nettype none

package bcpe_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF  = 16;
  localparam int GUARD_BITS      = 16;
  localparam int DEGREE_BITS     = 2;
  localparam int STEP_BITS       = 2;
  localparam int NUM_COEF        = 4;
  localparam int CFG_IDX_BITS    = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEGREE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT3 = 3'd4;

  localparam logic [DEGREE_BITS-1:0] DEGREE_CONST  = 2'd0;
  localparam logic [DEGREE_BITS-1:0] DEGREE_LINEAR = 2'd1;
  localparam logic [DEGREE_BITS-1:0] DEGREE_QUAD   = 2'd2;
  localparam logic [DEGREE_BITS-1:0] DEGREE_CUBIC  = 2'd3;

  typedef enum logic [1:0] {
    FUNC_ADVANCE  = 2'd0,
    FUNC_RESTART  = 2'd1,
    FUNC_POSITION = 2'd2,
    FUNC_HOLD     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_ADD  = 2'd2,
    ST_FIN  = 2'd3
  } state_t;

  typedef struct packed {
    logic                 load;
    logic                 mul;
    logic                 add;
    logic                 fin;
    logic [STEP_BITS-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic [DEGREE_BITS-1:0] degree;
    logic                   out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/bcpe_if.sv =====
// item channels of the curve evaluator: command in, result out
// depends on bcpe_pkg for default widths
`default_nettype none

interface bcpe_in_if #(
  parameter int PHASE_BITS = bcpe_pkg::PHASE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [PHASE_BITS-1:0] phase_step;
  logic [PHASE_BITS-1:0] position;

  modport source (output valid, output func, output phase_step, output position,
                  input ready);
  modport sink (input valid, input func, input phase_step, input position,
                output ready);
endinterface

interface bcpe_out_if #(
  parameter int SAMPLE_BITS = bcpe_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = bcpe_pkg::PHASE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic [PHASE_BITS-1:0]         phase;

  modport source (output valid, output value, output phase, input ready);
  modport sink (input valid, input value, input phase, output ready);
endinterface

`default_nettype wire

// ===== design/bezier_curve_phase_evaluator.sv =====
// bezier curve phase evaluator, degree 0..3, horner's rule on one shared multiplier
// a new command is taken only while idle, so the next item waits until the current
// one is finished; the finish state waits while the previous result is still held,
// and each horner step uses a multiply state and a round/add state on the single multiplier
// reset: phase zero, degree 3, all control points zero, no result pending
`default_nettype none

module bezier_curve_phase_evaluator #(
  parameter int SAMPLE_BITS = bcpe_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = bcpe_pkg::PHASE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [bcpe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]            cfg_data,
  bcpe_in_if.sink                                cmd,
  bcpe_out_if.source                             res
);
  import bcpe_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       in_ready;

  assign cmd.ready = in_ready;

  bcpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  bcpe_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (cmd.func),
    .phase_step (cmd.phase_step),
    .position   (cmd.position),
    .cmd        (dp_cmd),
    .status     (dp_status),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_value  (res.value),
    .out_phase  (res.phase)
  );

endmodule

`default_nettype wire

// ===== design/bcpe_ctrl.sv =====
// sequencer for the horner evaluation: accept, multiply/add per step, finish
// depends on bcpe_pkg and assert_macros.svh
`default_nettype none

module bcpe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bcpe_pkg::dp_status_t status,
  output bcpe_pkg::dp_cmd_t         cmd
);
  import bcpe_pkg::*;
  `include "assert_macros.svh"

  state_t               state, state_next;
  logic [STEP_BITS-1:0] cnt, cnt_next;
  logic                 accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_next   = STEP_BITS'(1);
          state_next = (status.degree == DEGREE_CONST) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        if (cnt == status.degree) begin
          state_next = ST_FIN;
        end else begin
          cnt_next   = cnt + STEP_BITS'(1);
          state_next = ST_MUL;
        end
      end
      ST_FIN: begin
        // wait here while the previous result is still held
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.load = accept;
    cmd.mul  = (state == ST_MUL);
    cmd.add  = (state == ST_ADD);
    cmd.fin  = (state == ST_FIN) && status.out_free;
    cmd.step = cnt;
  end

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != ST_IDLE)
  `ASSERT_NEXT(a_fin_returns_idle, clk, rst, cmd.fin, state == ST_IDLE)
  `ASSERT_NEXT(a_last_step_fin, clk, rst, cmd.add && (cnt == status.degree),
               state == ST_FIN)

endmodule

`default_nettype wire

// ===== design/bcpe_dp.sv =====
// datapath: config registers, power-basis coefficients, phase accumulator,
// shared multiplier for horner steps and the result register; uses bcpe_pkg
`default_nettype none

module bcpe_dp #(
  parameter int SAMPLE_BITS = bcpe_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = bcpe_pkg::PHASE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bcpe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]               cfg_data,
  input  wire logic [1:0]                           func,
  input  wire logic [PHASE_BITS-1:0]                phase_step,
  input  wire logic [PHASE_BITS-1:0]                position,
  input  wire bcpe_pkg::dp_cmd_t                    cmd,
  output bcpe_pkg::dp_status_t                      status,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]             out_value,
  output logic [PHASE_BITS-1:0]                     out_phase
);
  import bcpe_pkg::*;
  `include "assert_macros.svh"

  localparam int S  = SAMPLE_BITS;
  localparam int P  = PHASE_BITS;
  localparam int G  = GUARD_BITS;
  localparam int CW = S + 4;          // coefficient width
  localparam int AW = S + 5 + G;      // accumulator width
  localparam int MW = AW - 1;         // accumulator magnitude width
  localparam int RW = MW + 1 - G;     // rounded result magnitude width
  localparam logic [MW+P:0] RND_P = (MW + P + 1)'(1) << (P - 1);
  localparam logic [MW:0]   RND_G = (MW + 1)'(1) << (G - 1);
  localparam logic [RW-1:0] POS_LIM = {{(RW - S + 1){1'b0}}, {(S - 1){1'b1}}};
  localparam logic [RW-1:0] NEG_LIM = {{(RW - S){1'b0}}, 1'b1, {(S - 1){1'b0}}};

  // configuration
  logic [DEGREE_BITS-1:0] degree;
  logic signed [S-1:0]    point0, point1, point2, point3;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEGREE_CUBIC;
      point0 <= '0;
      point1 <= '0;
      point2 <= '0;
      point3 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEGREE: degree <= cfg_data[DEGREE_BITS-1:0];
        CFG_POINT0: point0 <= cfg_data;
        CFG_POINT1: point1 <= cfg_data;
        CFG_POINT2: point2 <= cfg_data;
        CFG_POINT3: point3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // power-basis coefficients, highest power first, registered
  logic signed [CW-1:0] e0, e1, e2, e3;
  logic signed [CW-1:0] d10, d12, s02;
  logic signed [CW-1:0] coef_next [NUM_COEF];
  logic signed [CW-1:0] coef      [NUM_COEF];

  assign e0  = CW'(point0);
  assign e1  = CW'(point1);
  assign e2  = CW'(point2);
  assign e3  = CW'(point3);
  assign d10 = e1 - e0;
  assign d12 = e1 - e2;
  assign s02 = e2 + e0 - (e1 <<< 1);

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      coef_next[i] = '0;
    end
    case (degree)
      DEGREE_CONST: begin
        coef_next[0] = e0;
      end
      DEGREE_LINEAR: begin
        coef_next[0] = d10;
        coef_next[1] = e0;
      end
      DEGREE_QUAD: begin
        coef_next[0] = s02;
        coef_next[1] = d10 <<< 1;
        coef_next[2] = e0;
      end
      default: begin
        coef_next[0] = e3 - e0 + (d12 <<< 1) + d12;
        coef_next[1] = (s02 <<< 1) + s02;
        coef_next[2] = (d10 <<< 1) + d10;
        coef_next[3] = e0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= coef_next[i];
      end
    end
  end

  // phase and evaluation point
  logic [P-1:0] phase_q, phase_sum, u_q;

  assign phase_sum = phase_q + phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q <= '0;
    end else if (cmd.load) begin
      case (func)
        FUNC_ADVANCE: phase_q <= phase_sum;
        FUNC_RESTART: phase_q <= '0;
        default:      phase_q <= phase_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (func)
        FUNC_ADVANCE:  u_q <= phase_sum;
        FUNC_RESTART:  u_q <= '0;
        FUNC_POSITION: u_q <= position;
        default:       u_q <= phase_q;
      endcase
    end
  end

  // horner datapath: multiply magnitude, then round, restore sign and add
  logic signed [AW-1:0] acc;
  logic [AW-1:0]        acc_mag;
  logic [MW+P-1:0]      prod_q;
  logic                 neg_q;
  logic [MW+P:0]        prod_rnd;
  logic [MW:0]          step_mag;
  logic signed [AW-1:0] step_val;
  logic signed [CW-1:0] coef_sel;
  logic signed [AW-1:0] coef_term;
  logic signed [AW-1:0] c0_term;

  assign acc_mag   = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign prod_rnd  = {1'b0, prod_q} + RND_P;
  assign step_mag  = prod_rnd[MW+P:P];
  assign step_val  = neg_q ? -AW'(step_mag) : AW'(step_mag);
  assign coef_sel  = coef[cmd.step];
  assign coef_term = {coef_sel[CW-1], coef_sel, {G{1'b0}}};
  // leading coefficient taken from coef_next, ahead of its register, so a write just before is seen
  assign c0_term   = {coef_next[0][CW-1], coef_next[0], {G{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= acc_mag[MW-1:0] * u_q;
      neg_q  <= acc[AW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= c0_term;
    end else if (cmd.add) begin
      acc <= step_val + coef_term;
    end
  end

  // final rounding and saturation
  logic [MW:0]          fin_sum;
  logic [RW-1:0]        fin_mag;
  logic                 fin_neg;
  logic signed [S-1:0]  fin_value;

  assign fin_sum = {1'b0, acc_mag[MW-1:0]} + RND_G;
  assign fin_mag = fin_sum[MW:G];
  assign fin_neg = acc[AW-1];

  always_comb begin
    if (!fin_neg && (fin_mag > POS_LIM)) begin
      fin_value = {1'b0, {(S - 1){1'b1}}};
    end else if (fin_neg && (fin_mag > NEG_LIM)) begin
      fin_value = {1'b1, {(S - 1){1'b0}}};
    end else if (fin_neg) begin
      fin_value = -fin_mag[S-1:0];
    end else begin
      fin_value = fin_mag[S-1:0];
    end
  end

  // result register, parts the output side from the evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_value <= fin_value;
      out_phase <= phase_q;
    end
  end

  assign status.degree   = degree;
  assign status.out_free = !out_valid || out_ready;

  `ASSERT_NEXT(a_fin_gives_item, clk, rst, cmd.fin, out_valid)
  `ASSERT_NEXT(a_restart_clears, clk, rst,
               cmd.load && (func == FUNC_RESTART), phase_q == '0)
  `ASSERT_SAME(a_one_command, clk, rst, cmd.load,
               !cmd.mul && !cmd.add && !cmd.fin)

endmodule

`default_nettype wire
